[sv/eit_pkg.sv]
// ----------------------------------------------------------------------------
// eit_pkg
// Shared constants and types for the edge intern table: field widths,
// length limits and the token that walks down the chain of compare cells.
// ----------------------------------------------------------------------------
package eit_pkg;

  // pixel and result field widths
  localparam int CHAN_W    = 8;
  localparam int PX_W      = 3 * CHAN_W;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_W     = 8;

  // edge length register
  localparam int LEN_W     = 5;
  localparam int LEN_MAX   = 16;
  localparam int POS_W     = 4;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(LEN_MAX);

  // default sizes for the top-level parameters
  localparam int DEF_MAX_EDGES = 64;
  localparam int DEF_EDGE_LEN  = 16;

  // flags of one compare token travelling down the cell chain
  typedef struct packed {
    logic valid;
    logic ok;
  } tok_t;

endpackage

[sv/eit_cell.sv]
// ----------------------------------------------------------------------------
// eit_cell
// One pixel position of the table. Holds that position's pixel of every
// stored edge in a local memory and the candidate's pixel, and refines the
// match flag of each token that passes through on its way down the chain.
// ----------------------------------------------------------------------------
module eit_cell #(
  parameter int MAX_EDGES = eit_pkg::DEF_MAX_EDGES,
  parameter int CELL_IDX  = 0,
  parameter int IDX_W     = $clog2(MAX_EDGES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [eit_pkg::LEN_W-1:0]   len_i,
  input  logic [eit_pkg::POS_W-1:0]   pos_i,
  input  logic                        load_i,
  input  logic [eit_pkg::PX_W-1:0]    px_i,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  eit_pkg::tok_t               tin_i,
  input  logic [IDX_W-1:0]            tin_idx_i,
  output eit_pkg::tok_t               tout_o,
  output logic [IDX_W-1:0]            tout_idx_o
);

  logic [eit_pkg::PX_W-1:0] store_mem [MAX_EDGES];
  logic [eit_pkg::PX_W-1:0] rd_r;
  logic [eit_pkg::PX_W-1:0] cand_r;
  eit_pkg::tok_t            tok_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     active;
  logic                     my_load;

  // this position takes part in the compare only below the edge length
  assign active  = (CELL_IDX < 32'(len_i));
  assign my_load = load_i && (CELL_IDX < eit_pkg::LEN_MAX) &&
                   (pos_i == eit_pkg::POS_W'(CELL_IDX));

  // candidate pixel for this position
  always_ff @(posedge clk) begin
    if (my_load) begin
      cand_r <= px_i;
    end
  end

  // column memory: append write, registered read at the incoming token
  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      store_mem[wr_addr_i] <= active ? cand_r : '0;
    end
    rd_r <= store_mem[tin_idx_i];
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tin_i;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= tin_idx_i;
  end

  // refine the match flag and hand on to the neighbour
  always_comb begin
    tout_o.valid = tok_r.valid;
    tout_o.ok    = tok_r.ok && (!active || (rd_r == cand_r));
    tout_idx_o   = idx_r;
  end

endmodule

[sv/edge_intern_table_core.sv]
// ----------------------------------------------------------------------------
// edge_intern_table_core
// Interns pixel edges: groups edge_length pixels into a candidate edge,
// looks it up among the stored edges and returns the first matching index,
// or appends it as a new entry, or reports a full table.
// ----------------------------------------------------------------------------
//  channel | direction | tdata bits (low to high)               | handshake
//  in_     | slave     | red[7:0] green[15:8] blue[23:16]       | tvalid/tready
//  out_    | master    | edge_index[5:0] is_new[6] table_full[7]| tvalid/tready
//  cfg_    | write     | edge_length[4:0]                       | wr_en only
//
//  A pixel that does not complete an edge leaves in_tready high.
//  A completing pixel holds in_tready low while the search runs: one token
//  per stored entry enters the cell chain each cycle and passes all EDGE_LEN
//  cells, each with its own token register. The result then waits for a free
//  output register, with in_tready still low.
//  Reset clears the count and the position; column memories are not cleared.
// ----------------------------------------------------------------------------
module edge_intern_table_core #(
  parameter int MAX_EDGES = eit_pkg::DEF_MAX_EDGES,
  parameter int EDGE_LEN  = eit_pkg::DEF_EDGE_LEN
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // red, green, blue
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [eit_pkg::PX_W-1:0]    in_tdata,
  // edge_index, is_new, table_full
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [eit_pkg::OUT_W-1:0]   out_tdata,
  // edge_length
  input  logic                        cfg_wr_en,
  input  logic [eit_pkg::LEN_W-1:0]   cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_EDGES);
  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [eit_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [eit_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CNT_W-1:0]            issue_r, issue_nxt;
  logic [CNT_W-1:0]            drain_r, drain_nxt;
  logic                        hit_r, hit_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [eit_pkg::OUT_W-1:0]   out_data_r, out_data_nxt;
  logic [eit_pkg::LEN_W-1:0]   eff_len;
  logic                        in_acc;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;

  eit_pkg::tok_t               gen_tok;
  logic [IDX_W-1:0]            gen_idx;
  eit_pkg::tok_t               chain_tok [EDGE_LEN+1];
  logic [IDX_W-1:0]            chain_idx [EDGE_LEN+1];
  eit_pkg::tok_t               exit_tok;
  logic [IDX_W-1:0]            exit_idx;

  // effective edge length: clamped to one..sixteen and to the cell count
  always_comb begin
    eff_len = len_r;
    if (eff_len == '0) begin
      eff_len = eit_pkg::LEN_W'(1);
    end
    if (32'(eff_len) > eit_pkg::LEN_MAX) begin
      eff_len = eit_pkg::LEN_W'(eit_pkg::LEN_MAX);
    end
    if (32'(eff_len) > EDGE_LEN) begin
      eff_len = eit_pkg::LEN_W'(EDGE_LEN);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // token generator feeding the first cell
  always_comb begin
    gen_tok.valid = (state_r == ST_SEARCH) && (issue_r < count_r);
    gen_tok.ok    = 1'b1;
    gen_idx       = issue_r[IDX_W-1:0];
  end

  assign chain_tok[0] = gen_tok;
  assign chain_idx[0] = gen_idx;

  // chain of compare cells, one per pixel position
  for (genvar g = 0; g < EDGE_LEN; g++) begin : g_cell
    eit_cell #(
      .MAX_EDGES (MAX_EDGES),
      .CELL_IDX  (g),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .len_i      (eff_len),
      .pos_i      (pos_r),
      .load_i     (in_acc),
      .px_i       (in_tdata),
      .wr_en_i    (wr_en),
      .wr_addr_i  (wr_addr),
      .tin_i      (chain_tok[g]),
      .tin_idx_i  (chain_idx[g]),
      .tout_o     (chain_tok[g+1]),
      .tout_idx_o (chain_idx[g+1])
    );
  end

  assign exit_tok = chain_tok[EDGE_LEN];
  assign exit_idx = chain_idx[EDGE_LEN];

  // control: pixel intake, search sweep, result and append
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    drain_nxt     = drain_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_wr_en) begin
          len_nxt = cfg_wr_data;
          pos_nxt = '0;
        end else if (in_acc) begin
          if (({1'b0, pos_r} + eit_pkg::LEN_W'(1)) == eff_len) begin
            pos_nxt   = '0;
            issue_nxt = '0;
            drain_nxt = '0;
            hit_nxt   = 1'b0;
            state_nxt = ST_SEARCH;
          end else begin
            pos_nxt = pos_r + eit_pkg::POS_W'(1);
          end
        end
      end
      ST_SEARCH: begin
        if (gen_tok.valid) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        // tokens leave in index order, so the first hit is the lowest
        if (exit_tok.valid) begin
          drain_nxt = drain_r + CNT_W'(1);
          if (exit_tok.ok && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = exit_idx;
          end
        end
        if (drain_r == count_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (hit_r) begin
            out_data_nxt = {1'b0, 1'b0, eit_pkg::OUT_IDX_W'(hit_idx_r)};
          end else if (count_r == CNT_W'(MAX_EDGES)) begin
            out_data_nxt = {1'b1, 1'b0, eit_pkg::OUT_IDX_W'(0)};
          end else begin
            out_data_nxt = {1'b0, 1'b1, eit_pkg::OUT_IDX_W'(count_r)};
            wr_en        = 1'b1;
            count_nxt    = count_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= eit_pkg::LEN_RESET;
      pos_r       <= '0;
      count_r     <= '0;
      issue_r     <= '0;
      drain_r     <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      drain_r     <= drain_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/eit_checker.sv]
// ----------------------------------------------------------------------------
// eit_checker
// Port-level checks for the edge intern table, bound to the top level.
// ----------------------------------------------------------------------------
module eit_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [eit_pkg::OUT_W-1:0]   out_tdata,
  input logic                        cfg_wr_en
);

  // a waiting result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // new and full never together
  a_new_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[6] && out_tdata[7]))
    else $error("is_new and table_full both set");

  // a full table reports index zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[5:0] == '0)
    else $error("table_full with nonzero index");

  // the input only stalls after taking an item
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid))
    else $error("in_tready fell without an accepted item");

  // length writes only arrive while no search is running
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> in_tready)
    else $error("edge_length written during a search");

endmodule

bind edge_intern_table_core eit_checker u_eit_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_wr_en   (cfg_wr_en)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for edge_intern_table_core. Pixels stream in on the
// in_ channel, lookup results are checked as they leave on the out_ channel
// against a behavioural copy of the edge table kept here. A short directed
// table opens the run, then random phases follow, each with a new edge length
// and a mix of repeated, near-miss, pool-based and random edges.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_W        = eit_pkg::CHAN_W;
  localparam int PX_W          = eit_pkg::PX_W;
  localparam int OUT_IDX_W     = eit_pkg::OUT_IDX_W;
  localparam int OUT_W         = eit_pkg::OUT_W;
  localparam int LEN_W         = eit_pkg::LEN_W;
  localparam int LEN_MAX       = eit_pkg::LEN_MAX;
  localparam int MAX_EDGES     = eit_pkg::DEF_MAX_EDGES;
  localparam int EDGE_LEN      = eit_pkg::DEF_EDGE_LEN;
  localparam int ITEMS_TOTAL   = 1950;
  localparam int QUIET_ITEMS   = 200;
  localparam int SETTLE_CYCLES = MAX_EDGES + EDGE_LEN + 16;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int POOL_SIZE     = 6;

  // pixel as carried on in_tdata, red in the lowest byte
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // lookup result as carried on out_tdata, edge_index in the lowest bits
  typedef struct packed {
    logic                 table_full;
    logic                 is_new;
    logic [OUT_IDX_W-1:0] edge_index;
  } lookup_t;

  typedef logic [EDGE_LEN*PX_W-1:0] edge_bits_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PIXEL
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [PX_W-1:0] value;
    logic [4:0]      reps;
    logic            typed;
    lookup_t         want;
  } stim_row_t;

  localparam int N_ROWS = 17;

  // opening sequence: clamped lengths, extremes, rewrite mid-edge, stale zeros
  localparam stim_row_t OPENING [N_ROWS] = '{
    '{ROW_CFG,   24'h000000, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'h000000, 5'd1,  1'b1, '{1'b0, 1'b1, 6'd0}},
    '{ROW_PIXEL, 24'hFFFFFF, 5'd1,  1'b1, '{1'b0, 1'b1, 6'd1}},
    '{ROW_PIXEL, 24'h000000, 5'd1,  1'b1, '{1'b0, 1'b0, 6'd0}},
    '{ROW_CFG,   24'h000002, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'h123456, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_CFG,   24'h000002, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'hABCDEF, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'h00FF00, 5'd1,  1'b1, '{1'b0, 1'b1, 6'd2}},
    '{ROW_CFG,   24'h000003, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'hABCDEF, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'h00FF00, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'h000000, 5'd1,  1'b1, '{1'b0, 1'b0, 6'd2}},
    '{ROW_CFG,   24'h00001F, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'h000000, 5'd15, 1'b0, '{1'b0, 1'b0, 6'd0}},
    '{ROW_PIXEL, 24'h000000, 5'd1,  1'b1, '{1'b0, 1'b0, 6'd0}},
    '{ROW_CFG,   24'h000010, 5'd1,  1'b0, '{1'b0, 1'b0, 6'd0}}
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [PX_W-1:0]   in_tdata    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data = '0;

  // shadow of the edge table
  pixel_t            table_mem [MAX_EDGES][EDGE_LEN];
  pixel_t            cand [EDGE_LEN];
  int unsigned       n_stored  = 0;
  int unsigned       fill_pos  = 0;
  logic [LEN_W-1:0]  len_reg   = eit_pkg::LEN_RESET;

  lookup_t           lookup_q [$];
  edge_bits_t        sent_edges [$];
  pixel_t            shade_pool [POOL_SIZE];

  int                err_count   = 0;
  int                results_seen = 0;
  int                items_sent  = 0;
  int                cycle_count = 0;
  bit                quiet       = 1'b0;

  edge_intern_table_core #(
    .MAX_EDGES (MAX_EDGES),
    .EDGE_LEN  (EDGE_LEN)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // effective length: clamped to 1..16 and to the table width
  function automatic int unsigned active_len();
    int unsigned n;
    n = 32'(len_reg);
    if (n < 1) n = 1;
    if (n > LEN_MAX) n = LEN_MAX;
    if (n > EDGE_LEN) n = EDGE_LEN;
    return n;
  endfunction

  // add one pixel to the candidate; on a completed edge look it up or append
  function automatic bit intern_pixel(input pixel_t px, output lookup_t res);
    int unsigned n;
    int          hit;
    int          e;
    int          i;
    bit          same;
    n = active_len();
    res = '0;
    if (fill_pos >= n) fill_pos = 0;
    cand[fill_pos] = px;
    fill_pos++;
    if (fill_pos < n) return 1'b0;
    fill_pos = 0;
    hit = -1;
    for (e = 0; e < int'(n_stored) && hit < 0; e++) begin
      same = 1'b1;
      for (i = 0; i < int'(n); i++) begin
        if (table_mem[e][i] != cand[i]) same = 1'b0;
      end
      if (same) hit = e;
    end
    if (hit >= 0) begin
      res.edge_index = OUT_IDX_W'(hit);
    end else if (n_stored >= MAX_EDGES) begin
      res.table_full = 1'b1;
    end else begin
      // entries are stored zero-padded beyond the current length
      for (i = 0; i < EDGE_LEN; i++) begin
        table_mem[n_stored][i] = (i < int'(n)) ? cand[i] : pixel_t'('0);
      end
      res.edge_index = OUT_IDX_W'(n_stored);
      res.is_new = 1'b1;
      n_stored++;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    err_count++;
    if (err_count <= 100)
      $display("result %0d: %s got %0d, expected %0d", results_seen, field, got, want);
  endtask

  // offer one pixel and hold it until accepted; valid stays high afterwards
  task automatic send_pixel(input pixel_t px, input bit typed, input lookup_t typed_want);
    lookup_t want;
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (items_sent >= ITEMS_TOTAL - QUIET_ITEMS) quiet = 1'b1;
    if (intern_pixel(px, want)) lookup_q.insert(lookup_q.size(), typed ? typed_want : want);
  endtask

  // wait for the table to drain, then write the length register
  task automatic set_edge_length(input logic [LEN_W-1:0] value);
    in_tvalid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    len_reg  = value;
    fill_pos = 0;
  endtask

  // stream the first count pixels of an edge, with random gaps if allowed
  task automatic send_edge(input edge_bits_t bits, input int unsigned count, input bit gappy);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (gappy && !quiet && $urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      send_pixel(bits[k*PX_W +: PX_W], 1'b0, '0);
    end
  endtask

  // result sink back-pressure: ready stretches broken by short stalls
  initial begin
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  end

  // result check against the oldest pending lookup
  always @(posedge clk) begin : result_check
    lookup_t got;
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (lookup_q.size() == 0) begin
        report_mismatch("unrequested result, edge_index", int'(got.edge_index), 0);
      end else begin
        want = lookup_q.pop_front();
        if (got.edge_index !== want.edge_index)
          report_mismatch("edge_index", int'(got.edge_index), int'(want.edge_index));
        if (got.is_new !== want.is_new)
          report_mismatch("is_new", int'(got.is_new), int'(want.is_new));
        if (got.table_full !== want.table_full)
          report_mismatch("table_full", int'(got.table_full), int'(want.table_full));
      end
    end
  end

  // stimulus
  initial begin
    int          r;
    int          pick;
    int unsigned n;
    int unsigned n_edges;
    int unsigned k;
    int unsigned len_val;
    bit          gappy;
    edge_bits_t  bits;
    pixel_t      px;

    shade_pool[0] = '0;
    shade_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) shade_pool[k] = pixel_t'($urandom);

    // reset
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening directed sequence
    for (r = 0; r < N_ROWS; r++) begin
      if (OPENING[r].kind == ROW_CFG) begin
        set_edge_length(OPENING[r].value[LEN_W-1:0]);
      end else begin
        repeat (OPENING[r].reps)
          send_pixel(OPENING[r].value, OPENING[r].typed, OPENING[r].want);
      end
    end

    // random phases, each under one edge length
    while (items_sent < ITEMS_TOTAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) len_val = $urandom_range(1, 3);
      else if (pick < 15) len_val = $urandom_range(4, 8);
      else if (pick < 18) len_val = $urandom_range(9, 16);
      else if (pick == 18) len_val = 0;
      else len_val = $urandom_range(17, 31);
      set_edge_length(LEN_W'(len_val));
      n = active_len();
      gappy = ($urandom_range(0, 2) != 0);
      n_edges = $urandom_range(2, 2 + 64 / n);

      repeat (n_edges) begin
        pick = $urandom_range(0, 9);
        if (pick < 4 && sent_edges.size() != 0) begin
          // repeat of an earlier edge, possibly stored under another length
          bits = sent_edges[$urandom_range(0, sent_edges.size() - 1)];
        end else if (pick < 6 && sent_edges.size() != 0) begin
          // near miss: one flipped bit in one pixel
          bits = sent_edges[$urandom_range(0, sent_edges.size() - 1)];
          k = $urandom_range(0, n - 1);
          bits[k*PX_W + $urandom_range(0, PX_W - 1)] ^= 1'b1;
        end else if (pick < 8) begin
          for (k = 0; k < EDGE_LEN; k++)
            bits[k*PX_W +: PX_W] = shade_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          for (k = 0; k < EDGE_LEN; k++) begin
            px = pixel_t'($urandom);
            bits[k*PX_W +: PX_W] = px;
          end
        end
        for (k = n; k < EDGE_LEN; k++) bits[k*PX_W +: PX_W] = '0;
        send_edge(bits, n, gappy);
        sent_edges.insert(sent_edges.size(), bits);
      end

      // occasionally leave a partial edge for the next length write to discard
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        for (k = 0; k < EDGE_LEN; k++) bits[k*PX_W +: PX_W] = pixel_t'($urandom);
        send_edge(bits, $urandom_range(1, n - 1), gappy);
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
